@@ src/lcdseq_pkg.sv @@
package lcdseq_pkg;

    // Decimal conversion: number of digit positions kept for a written number.
    localparam int MAX_DIGITS  = 20;
    localparam int BCD_W       = 4 * MAX_DIGITS;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int NUM_W       = 64;
    localparam int CONV_CNT_W  = $clog2(NUM_W);

    // Byte queue between the request decoder and the strobe generator.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;

    // Controller command bytes.
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_ENTRY   = 8'h06;
    localparam logic [7:0] CMD_DISPLAY = 8'h0C;
    localparam logic [7:0] CMD_BUS8    = 8'h38;
    localparam logic [7:0] CMD_BUS4    = 8'h28;
    localparam logic [7:0] CURSOR_BASE = 8'h80;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    // Delays in milliseconds.
    localparam logic [6:0] INIT_WAIT_MS = 7'd100;
    localparam logic [3:0] AFTER_SHORT  = 4'd2;
    localparam logic [3:0] AFTER_DATA   = 4'd5;
    localparam logic [3:0] AFTER_MODE   = 4'd6;
    localparam logic [3:0] AFTER_CLEAR  = 4'd11;

    // Reset values of the configuration registers.
    localparam logic [2:0] ROW_LIMIT_RST    = 3'd2;
    localparam logic [5:0] COLUMN_LIMIT_RST = 6'd16;

    typedef enum logic [2:0] {
        REQ_INIT   = 3'd0,
        REQ_CHAR   = 3'd1,
        REQ_MOVE   = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_NUMBER = 3'd4
    } t_req_type;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BUS_MODE       = 3'd0,
        CFG_CURSOR_VISIBLE = 3'd1,
        CFG_CURSOR_BLINK   = 3'd2,
        CFG_ROW_LIMIT      = 3'd3,
        CFG_COLUMN_LIMIT   = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONVERT,
        FR_EMIT
    } t_front_state;

    typedef enum logic {
        BK_BYTE,
        BK_LOW_NIBBLE
    } t_back_state;

    typedef struct packed {
        logic       bus_mode;
        logic       cursor_visible;
        logic       cursor_blink;
        logic [2:0] row_limit;
        logic [5:0] column_limit;
    } t_cfg;

    // One byte to be sent to the display, with its delays.
    typedef struct packed {
        logic       reg_select;
        logic [7:0] data;
        logic [6:0] wait_before;
        logic [3:0] wait_after;
        logic       last;
    } t_byte_cmd;

endpackage

@@ src/lcdseq_front.sv @@
module lcdseq_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_stall,
    input  logic [2:0]                       i_req_type,
    input  logic [7:0]                       i_char_code,
    input  logic [7:0]                       i_row_index,
    input  logic [7:0]                       i_column_index,
    input  logic [lcdseq_pkg::NUM_W-1:0]     i_number_value,
    input  lcdseq_pkg::t_cfg                 i_cfg,
    output logic                             o_push,
    output lcdseq_pkg::t_byte_cmd            o_cmd,
    input  logic                             i_full
);

    // Add three to every BCD digit of five or more, ahead of the shift.
    function automatic logic [lcdseq_pkg::BCD_W-1:0] dabble_adjust(
        input logic [lcdseq_pkg::BCD_W-1:0] bcd
    );
        logic [lcdseq_pkg::BCD_W-1:0] adj;
        logic [3:0]                   d;
        adj = bcd;
        for (int i = 0; i < lcdseq_pkg::MAX_DIGITS; i++) begin
            d = bcd[4*i +: 4];
            adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        return adj;
    endfunction

    // Byte sequence of the display start-up.
    function automatic lcdseq_pkg::t_byte_cmd init_entry(
        input lcdseq_pkg::t_cfg cfg,
        input logic [2:0]       idx
    );
        lcdseq_pkg::t_byte_cmd c;
        logic [7:0]            disp;
        disp = lcdseq_pkg::CMD_DISPLAY | {6'd0, cfg.cursor_visible, cfg.cursor_blink};
        c = '0;
        if (cfg.bus_mode) begin
            unique case (idx)
                3'd0: begin
                    c.data = lcdseq_pkg::CMD_HOME;
                    c.wait_before = lcdseq_pkg::INIT_WAIT_MS;
                    c.wait_after = lcdseq_pkg::AFTER_MODE;
                end
                3'd1: begin
                    c.data = lcdseq_pkg::CMD_BUS4;
                    c.wait_after = lcdseq_pkg::AFTER_SHORT;
                end
                3'd2: begin
                    c.data = disp;
                    c.wait_after = lcdseq_pkg::AFTER_SHORT;
                end
                3'd3: begin
                    c.data = lcdseq_pkg::CMD_CLEAR;
                    c.wait_after = lcdseq_pkg::AFTER_CLEAR;
                end
                default: begin
                    c.data = lcdseq_pkg::CMD_ENTRY;
                    c.wait_after = lcdseq_pkg::AFTER_SHORT;
                    c.last = 1'b1;
                end
            endcase
        end else begin
            unique case (idx)
                3'd0: begin
                    c.data = lcdseq_pkg::CMD_BUS8;
                    c.wait_before = lcdseq_pkg::INIT_WAIT_MS;
                    c.wait_after = lcdseq_pkg::AFTER_SHORT;
                end
                3'd1: begin
                    c.data = disp;
                    c.wait_after = lcdseq_pkg::AFTER_SHORT;
                end
                3'd2: begin
                    c.data = lcdseq_pkg::CMD_CLEAR;
                    c.wait_after = lcdseq_pkg::AFTER_CLEAR;
                end
                default: begin
                    c.data = lcdseq_pkg::CMD_ENTRY;
                    c.wait_after = lcdseq_pkg::AFTER_MODE;
                    c.last = 1'b1;
                end
            endcase
        end
        return c;
    endfunction

    lcdseq_pkg::t_front_state                r_state, n_state;
    lcdseq_pkg::t_req_type                   r_type;
    logic [7:0]                              r_char;
    logic [7:0]                              r_addr;
    logic [lcdseq_pkg::NUM_W-1:0]            r_bin;
    logic [lcdseq_pkg::BCD_W-1:0]            r_bcd;
    logic [lcdseq_pkg::CONV_CNT_W-1:0]       r_cnt;
    logic [lcdseq_pkg::DIGIT_IDX_W-1:0]      r_idx;
    logic                                    r_started;

    logic                                    w_accept;
    logic                                    w_step;
    logic                                    w_finish;
    logic [7:0]                              w_addr;
    logic [lcdseq_pkg::BCD_W-1:0]            w_adj;
    logic [3:0]                              w_digit;
    logic                                    w_digit_nz;
    logic                                    w_idx_zero;

    assign o_req_stall = (r_state != lcdseq_pkg::FR_IDLE);
    assign w_accept    = i_req_valid && (r_state == lcdseq_pkg::FR_IDLE);
    assign w_adj       = dabble_adjust(r_bcd);
    assign w_digit     = r_bcd[lcdseq_pkg::BCD_W-1 -: 4];
    assign w_digit_nz  = (w_digit != 4'd0);
    assign w_idx_zero  = (r_idx == '0);

    // Cursor address, or the home address when the target lies beyond the limits.
    always_comb begin
        if ((i_row_index > {5'd0, i_cfg.row_limit})
                || (i_column_index > {2'd0, i_cfg.column_limit})) begin
            w_addr = lcdseq_pkg::CURSOR_BASE;
        end else begin
            w_addr = lcdseq_pkg::CURSOR_BASE + {1'b0, i_row_index[0], 6'd0}
                     + i_column_index + {i_row_index[4:1], 4'd0};
        end
    end

    // Byte generation.
    always_comb begin
        o_push   = 1'b0;
        o_cmd    = '0;
        w_step   = 1'b0;
        w_finish = 1'b0;
        if (r_state == lcdseq_pkg::FR_EMIT) begin
            unique case (r_type)
                lcdseq_pkg::REQ_INIT: begin
                    o_cmd    = init_entry(i_cfg, r_idx[2:0]);
                    o_push   = 1'b1;
                    w_step   = !i_full;
                    w_finish = !i_full && o_cmd.last;
                end
                lcdseq_pkg::REQ_CHAR: begin
                    o_cmd.reg_select = 1'b1;
                    o_cmd.data       = r_char;
                    o_cmd.wait_after = lcdseq_pkg::AFTER_DATA;
                    o_cmd.last       = 1'b1;
                    o_push           = 1'b1;
                    w_finish         = !i_full;
                end
                lcdseq_pkg::REQ_MOVE: begin
                    o_cmd.data       = r_addr;
                    o_cmd.wait_after = lcdseq_pkg::AFTER_SHORT;
                    o_cmd.last       = 1'b1;
                    o_push           = 1'b1;
                    w_finish         = !i_full;
                end
                lcdseq_pkg::REQ_CLEAR: begin
                    o_cmd.data       = lcdseq_pkg::CMD_CLEAR;
                    o_cmd.wait_after = lcdseq_pkg::AFTER_CLEAR;
                    o_cmd.last       = 1'b1;
                    o_push           = 1'b1;
                    w_finish         = !i_full;
                end
                lcdseq_pkg::REQ_NUMBER: begin
                    // Leading zeros are skipped; the units digit always goes out.
                    o_cmd.reg_select = 1'b1;
                    o_cmd.data       = lcdseq_pkg::CHAR_ZERO | {4'd0, w_digit};
                    o_cmd.wait_after = lcdseq_pkg::AFTER_DATA;
                    o_cmd.last       = w_idx_zero;
                    o_push           = r_started || w_digit_nz || w_idx_zero;
                    w_step           = !o_push || !i_full;
                    w_finish         = w_step && w_idx_zero;
                end
                default: begin
                    w_finish = 1'b1;
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcdseq_pkg::FR_IDLE: begin
                if (i_req_valid) begin
                    priority if (i_req_type == lcdseq_pkg::REQ_NUMBER) begin
                        n_state = lcdseq_pkg::FR_CONVERT;
                    end else if (i_req_type < lcdseq_pkg::REQ_NUMBER) begin
                        n_state = lcdseq_pkg::FR_EMIT;
                    end else begin
                        n_state = lcdseq_pkg::FR_IDLE;
                    end
                end
            end
            lcdseq_pkg::FR_CONVERT: begin
                if (r_cnt == lcdseq_pkg::CONV_CNT_W'(lcdseq_pkg::NUM_W - 1)) begin
                    n_state = lcdseq_pkg::FR_EMIT;
                end
            end
            lcdseq_pkg::FR_EMIT: begin
                if (w_finish) begin
                    n_state = lcdseq_pkg::FR_IDLE;
                end
            end
            default: begin
                n_state = lcdseq_pkg::FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcdseq_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type    <= lcdseq_pkg::t_req_type'(i_req_type);
            r_char    <= i_char_code;
            r_addr    <= w_addr;
            r_bin     <= i_number_value;
            r_bcd     <= '0;
            r_cnt     <= '0;
            r_started <= 1'b0;
            if (i_req_type == lcdseq_pkg::REQ_NUMBER) begin
                r_idx <= lcdseq_pkg::DIGIT_IDX_W'(lcdseq_pkg::MAX_DIGITS - 1);
            end else begin
                r_idx <= '0;
            end
        end else if (r_state == lcdseq_pkg::FR_CONVERT) begin
            // Shift-and-add-three: one binary bit into the digit register per cycle.
            // A carry out of the top digit means the value has more digits than
            // kept, so all kept digits are written, zeros included.
            r_bcd     <= {w_adj[lcdseq_pkg::BCD_W-2:0], r_bin[lcdseq_pkg::NUM_W-1]};
            r_bin     <= {r_bin[lcdseq_pkg::NUM_W-2:0], 1'b0};
            r_started <= r_started | w_adj[lcdseq_pkg::BCD_W-1];
            r_cnt     <= r_cnt + 1'b1;
        end else if (w_step) begin
            if (r_type == lcdseq_pkg::REQ_NUMBER) begin
                r_bcd     <= {r_bcd[lcdseq_pkg::BCD_W-5:0], 4'd0};
                r_started <= r_started | w_digit_nz;
                r_idx     <= r_idx - 1'b1;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

@@ src/lcdseq_queue.sv @@
module lcdseq_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lcdseq_pkg::t_byte_cmd i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output lcdseq_pkg::t_byte_cmd o_head
);

    lcdseq_pkg::t_byte_cmd                r_mem [lcdseq_pkg::QUEUE_DEPTH];
    logic [lcdseq_pkg::QUEUE_PTR_W-1:0]   r_wr_ptr;
    logic [lcdseq_pkg::QUEUE_PTR_W-1:0]   r_rd_ptr;
    logic [lcdseq_pkg::QUEUE_CNT_W-1:0]   r_count;
    logic                                 w_wr;
    logic                                 w_rd;

    assign o_full  = (r_count == lcdseq_pkg::QUEUE_CNT_W'(lcdseq_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/lcdseq_back.sv @@
module lcdseq_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_bus_mode,
    input  logic                  i_empty,
    input  lcdseq_pkg::t_byte_cmd i_head,
    output logic                  o_pop,
    output logic                  o_strobe_valid,
    input  logic                  i_strobe_stall,
    output logic                  o_reg_select,
    output logic [7:0]            o_bus_value,
    output logic [6:0]            o_wait_before_ms,
    output logic [3:0]            o_wait_after_ms,
    output logic                  o_last_strobe
);

    lcdseq_pkg::t_back_state r_state, n_state;
    logic                    r_valid, n_valid;
    logic                    r_rs, n_rs;
    logic [7:0]              r_bus, n_bus;
    logic [6:0]              r_before, n_before;
    logic [3:0]              r_after, n_after;
    logic                    r_last, n_last;
    logic                    w_load;

    // The output register takes a new strobe when it is empty or being taken.
    assign w_load = !r_valid || !i_strobe_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcdseq_pkg::BK_BYTE: begin
                if (w_load && !i_empty && i_bus_mode) begin
                    n_state = lcdseq_pkg::BK_LOW_NIBBLE;
                end
            end
            lcdseq_pkg::BK_LOW_NIBBLE: begin
                if (w_load) begin
                    n_state = lcdseq_pkg::BK_BYTE;
                end
            end
            default: begin
                n_state = lcdseq_pkg::BK_BYTE;
            end
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        n_valid  = r_valid;
        n_rs     = r_rs;
        n_bus    = r_bus;
        n_before = r_before;
        n_after  = r_after;
        n_last   = r_last;
        if (w_load) begin
            unique case (r_state)
                lcdseq_pkg::BK_LOW_NIBBLE: begin
                    n_valid  = 1'b1;
                    n_rs     = i_head.reg_select;
                    n_bus    = {4'd0, i_head.data[3:0]};
                    n_before = '0;
                    n_after  = i_head.wait_after;
                    n_last   = i_head.last;
                    o_pop    = 1'b1;
                end
                default: begin
                    n_valid = !i_empty;
                    n_rs    = i_head.reg_select;
                    if (i_bus_mode) begin
                        // High nibble first; the byte stays queued for its low half.
                        n_bus    = {4'd0, i_head.data[7:4]};
                        n_before = i_head.wait_before;
                        n_after  = '0;
                        n_last   = 1'b0;
                    end else begin
                        n_bus    = i_head.data;
                        n_before = i_head.wait_before;
                        n_after  = i_head.wait_after;
                        n_last   = i_head.last;
                        o_pop    = !i_empty;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcdseq_pkg::BK_BYTE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rs     <= n_rs;
        r_bus    <= n_bus;
        r_before <= n_before;
        r_after  <= n_after;
        r_last   <= n_last;
    end

    assign o_strobe_valid   = r_valid;
    assign o_reg_select     = r_rs;
    assign o_bus_value      = r_bus;
    assign o_wait_before_ms = r_before;
    assign o_wait_after_ms  = r_after;
    assign o_last_strobe    = r_last;

endmodule

@@ src/char_lcd_bus_sequencer.sv @@
// Character-LCD bus sequencer. Each request transfer (start-up, write character,
// move cursor, clear, write unsigned number) becomes a series of strobe transfers,
// one per enable pulse, each giving register select, bus value, the wait before
// the strobe and the extra wait after the standard enable pulse; the final strobe
// of a request is marked with o_last_strobe. In four-bit mode every byte goes out
// as two strobes, high nibble first, with the nibble in bits 3..0. Request types
// five to seven produce no strobes. A request is taken in the cycle after the
// previous request has placed its last byte in the four-entry byte queue; a number
// request first runs the decimal conversion, one binary bit per cycle, and then
// steps through all 20 digit positions. The strobe side delivers one strobe per
// cycle while bytes are queued and the downstream side does not stall.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data and
// must only change while the block is idle.
module char_lcd_bus_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Request channel.
    input  logic                                 i_req_valid,
    output logic                                 o_req_stall,
    input  logic [2:0]                           i_req_type,
    input  logic [7:0]                           i_char_code,
    input  logic [7:0]                           i_row_index,
    input  logic [7:0]                           i_column_index,
    input  logic [lcdseq_pkg::NUM_W-1:0]         i_number_value,

    // Strobe channel.
    output logic                                 o_strobe_valid,
    input  logic                                 i_strobe_stall,
    output logic                                 o_reg_select,
    output logic [7:0]                           o_bus_value,
    output logic [6:0]                           o_wait_before_ms,
    output logic [3:0]                           o_wait_after_ms,
    output logic                                 o_last_strobe,

    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [lcdseq_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [lcdseq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lcdseq_pkg::t_cfg      r_cfg;
    logic                  w_push;
    lcdseq_pkg::t_byte_cmd w_push_cmd;
    logic                  w_full;
    logic                  w_pop;
    logic                  w_empty;
    lcdseq_pkg::t_byte_cmd w_head;

    // Configuration registers. Writes to indexes beyond the register list are
    // dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_mode       <= 1'b0;
            r_cfg.cursor_visible <= 1'b0;
            r_cfg.cursor_blink   <= 1'b0;
            r_cfg.row_limit      <= lcdseq_pkg::ROW_LIMIT_RST;
            r_cfg.column_limit   <= lcdseq_pkg::COLUMN_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (lcdseq_pkg::t_cfg_index'(i_cfg_index))
                lcdseq_pkg::CFG_BUS_MODE:       r_cfg.bus_mode       <= i_cfg_data[0];
                lcdseq_pkg::CFG_CURSOR_VISIBLE: r_cfg.cursor_visible <= i_cfg_data[0];
                lcdseq_pkg::CFG_CURSOR_BLINK:   r_cfg.cursor_blink   <= i_cfg_data[0];
                lcdseq_pkg::CFG_ROW_LIMIT:      r_cfg.row_limit      <= i_cfg_data[2:0];
                lcdseq_pkg::CFG_COLUMN_LIMIT:   r_cfg.column_limit   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end decodes each request into command and data bytes, running
    // the binary-to-decimal conversion for numbers.
    lcdseq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_stall    (o_req_stall),
        .i_req_type     (i_req_type),
        .i_char_code    (i_char_code),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_number_value (i_number_value),
        .i_cfg          (r_cfg),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd),
        .i_full         (w_full)
    );

    // The byte queue lets the decoder run ahead of a stalled strobe side.
    lcdseq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // The back end splits bytes into nibbles in four-bit mode and holds each
    // strobe in its output register until it is taken.
    lcdseq_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_bus_mode       (r_cfg.bus_mode),
        .i_empty          (w_empty),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_strobe_valid   (o_strobe_valid),
        .i_strobe_stall   (i_strobe_stall),
        .o_reg_select     (o_reg_select),
        .o_bus_value      (o_bus_value),
        .o_wait_before_ms (o_wait_before_ms),
        .o_wait_after_ms  (o_wait_after_ms),
        .o_last_strobe    (o_last_strobe)
    );

endmodule
